### sv/composition_rank_unrank_top_defines.svh
// Assertion macros for the composition rank/unrank block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef COMPOSITION_RANK_UNRANK_TOP_DEFINES_SVH
`define COMPOSITION_RANK_UNRANK_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CRK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CRK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/crk_pkg.sv
// Shared constants, beat types, state encodings and the Pascal-triangle table
// for the composition rank/unrank block. No dependencies.
package crk_pkg;

  localparam int Modes      = 8;
  localparam int MaxTotal   = 15;
  localparam int TableRows  = 24;
  localparam int FieldModes = 8;
  localparam int LaneModes  = (Modes < FieldModes) ? Modes : FieldModes;

  localparam int CountW    = 4;
  localparam int CountsW   = FieldModes * CountW;
  localparam int RankW     = 20;
  localparam int BinomW    = 21;
  localparam int TotalW    = 7;
  localparam int ModeW     = 4;
  localparam int DepthW    = 4;
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 4;
  localparam int RowIdxW   = $clog2(TableRows);
  localparam int FieldIdxW = $clog2(FieldModes);
  localparam int HeightW   = $clog2(MaxTotal + 1);
  localparam int NW        = TotalW + 1;
  localparam int PairCount = (LaneModes + 1) / 2;
  localparam int PairW     = BinomW + 1;
  localparam int SumW      = BinomW + $clog2(LaneModes + 1);

  localparam logic [ModeW-1:0]  ResetModes = ModeW'(8);
  localparam logic [DepthW-1:0] ResetDepth = DepthW'(15);
  localparam logic [RankW-1:0]  RankMax    = '1;

  typedef enum logic {
    OP_RANK   = 1'b0,
    OP_UNRANK = 1'b1
  } crk_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_MODES = CfgIdxW'(0),
    REG_DEPTH_LIMIT  = CfgIdxW'(1)
  } crk_reg_e;

  typedef enum logic [1:0] {
    US_IDLE,
    US_STEP,
    US_DONE
  } crk_ustate_e;

  typedef struct packed {
    logic               opcode;
    logic [CountsW-1:0] counts_in;
    logic [RankW-1:0]   rank_in;
  } crk_in_t;

  typedef struct packed {
    logic [RankW-1:0]   rank_out;
    logic [CountsW-1:0] counts_out;
    logic [TotalW-1:0]  total_out;
    logic               out_of_range;
  } crk_out_t;

  // Effective configuration handed to both engines
  typedef struct packed {
    logic [ModeW-1:0]   modes;
    logic [HeightW-1:0] depth;
  } crk_cfg_t;

  typedef logic [TableRows-1:0][TableRows-1:0][BinomW-1:0] binom_tab_t;

  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int n = 0; n < TableRows; n++) begin
      for (int k = 0; k <= n; k++) begin
        if (k == 0 || k == n) begin
          tab[n][k] = BinomW'(1);
        end else begin
          tab[n][k] = tab[n-1][k] + tab[n-1][k-1];
        end
      end
    end
    return tab;
  endfunction

  // C(n,k) for n below TableRows, zero above the diagonal
  localparam binom_tab_t Binom = build_binom();

endpackage

### sv/composition_rank_unrank_top.sv
// Rank: the beat passes the lane stage, pair-sum stage, merge stage and output
// register in that order; a result waits in the merge stage while out_stall_i holds.
// Unrank: one pass of the height lanes per mode, m being active_modes clamped
// to 1..8; an out-of-range index skips the passes and goes straight to done.
// One item in flight; the output register holds a result while a new beat enters.
// Reset: async active low; clears control and sets active_modes 8, depth_limit 15.
module composition_rank_unrank_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  crk_pkg::crk_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output crk_pkg::crk_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [crk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [crk_pkg::CfgDataW-1:0] cfg_data_i
);
  import crk_pkg::*;

  logic [ModeW-1:0]  modes_q;
  logic [DepthW-1:0] depth_q;
  crk_cfg_t          cfg;
  logic              busy_q, out_valid_q;
  crk_out_t          out_q;
  logic              accept, take;
  logic              r_start, u_start, r_done, u_done;
  crk_out_t          r_res, u_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q <= ResetModes;
      depth_q <= ResetDepth;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ACTIVE_MODES: modes_q <= ModeW'(cfg_data_i);
        REG_DEPTH_LIMIT:  depth_q <= DepthW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Clamp to the usable range
  always_comb begin
    if (modes_q == '0) begin
      cfg.modes = ModeW'(1);
    end else if (modes_q > ModeW'(LaneModes)) begin
      cfg.modes = ModeW'(LaneModes);
    end else begin
      cfg.modes = modes_q;
    end
    if (depth_q > DepthW'(MaxTotal)) begin
      cfg.depth = HeightW'(MaxTotal);
    end else begin
      cfg.depth = HeightW'(depth_q);
    end
  end

  assign accept  = in_valid_i && !in_stall_o;
  assign r_start = accept && (in_data_i.opcode == OP_RANK);
  assign u_start = accept && (in_data_i.opcode == OP_UNRANK);
  assign take    = (r_done || u_done) && (!out_valid_q || !out_stall_i);

  crk_rank u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (r_start),
    .counts_i (in_data_i.counts_in),
    .cfg_i    (cfg),
    .ack_i    (take),
    .done_o   (r_done),
    .res_o    (r_res)
  );

  crk_unrank u_unrank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (u_start),
    .rank_i  (in_data_i.rank_in),
    .cfg_i   (cfg),
    .ack_i   (take),
    .done_o  (u_done),
    .res_o   (u_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      out_valid_q <= take || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= r_done ? r_res : u_res;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/crk_rank.sv
// Rank engine: one lane per mode forms its suffix sum and binomial term,
// then a registered adder tree merges the lanes. Depends on crk_pkg.
module crk_rank (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [crk_pkg::CountsW-1:0] counts_i,
  input  crk_pkg::crk_cfg_t          cfg_i,
  input  logic                       ack_i,
  output logic                       done_o,
  output crk_pkg::crk_out_t          res_o
);
  import crk_pkg::*;

  logic [CountW-1:0]    lane_cnt [LaneModes];
  logic [TotalW-1:0]    lane_h   [LaneModes];
  logic [BinomW-1:0]    term_d   [LaneModes];
  logic [BinomW-1:0]    term_q   [LaneModes];
  logic [LaneModes-1:0] sat_d;
  logic [PairW-1:0]     pair_d   [PairCount];
  logic [PairW-1:0]     pair_q   [PairCount];
  logic                 sat1_q, sat2_q;
  logic [TotalW-1:0]    tot1_q, tot2_q;
  logic [HeightW-1:0]   dep1_q, dep2_q;
  logic [SumW-1:0]      sum;
  logic                 flag;
  logic                 v1_q, v2_q, done_q;
  crk_out_t             res_q;

  // Lane k = l+1 takes count of mode m-k when it is active
  for (genvar l = 0; l < LaneModes; l++) begin : g_lane
    logic [ModeW-1:0] sel;
    logic             act;
    logic [NW-1:0]    row;
    assign act         = cfg_i.modes > ModeW'(l);
    assign sel         = cfg_i.modes - ModeW'(l + 1);
    assign lane_cnt[l] = act ? counts_i[sel[FieldIdxW-1:0]*CountW +: CountW] : '0;
    assign row         = NW'(l) + NW'(lane_h[l]);
    assign sat_d[l]    = act && (row >= NW'(TableRows));
    assign term_d[l]   = (act && !sat_d[l]) ? Binom[row[RowIdxW-1:0]][l+1] : '0;
  end

  // Suffix sums across the lanes
  always_comb begin
    lane_h[0] = TotalW'(lane_cnt[0]);
    for (int l = 1; l < LaneModes; l++) begin
      lane_h[l] = lane_h[l-1] + TotalW'(lane_cnt[l]);
    end
  end

  for (genvar p = 0; p < PairCount; p++) begin : g_pair
    if (2 * p + 1 < LaneModes) begin : g_full
      assign pair_d[p] = PairW'(term_q[2*p]) + PairW'(term_q[2*p+1]);
    end else begin : g_odd
      assign pair_d[p] = PairW'(term_q[2*p]);
    end
  end

  always_comb begin
    sum = '0;
    for (int p = 0; p < PairCount; p++) begin
      sum = sum + SumW'(pair_q[p]);
    end
    flag = sat2_q || (tot2_q > TotalW'(dep2_q)) || (sum > SumW'(RankMax));
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      term_q <= term_d;
      sat1_q <= |sat_d;
      tot1_q <= lane_h[LaneModes-1];
      dep1_q <= cfg_i.depth;
    end
    if (v1_q) begin
      pair_q <= pair_d;
      sat2_q <= sat1_q;
      tot2_q <= tot1_q;
      dep2_q <= dep1_q;
    end
    if (v2_q) begin
      res_q.rank_out     <= flag ? '0 : sum[RankW-1:0];
      res_q.counts_out   <= '0;
      res_q.total_out    <= tot2_q;
      res_q.out_of_range <= flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q || (done_q && !ack_i);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### sv/crk_unrank.sv
// Unrank engine: one pass per mode, with a lane per candidate height that
// compares its binomial against the remainder; a priority merge picks the
// largest fit. Depends on crk_pkg.
module crk_unrank (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [crk_pkg::RankW-1:0] rank_i,
  input  crk_pkg::crk_cfg_t        cfg_i,
  input  logic                     ack_i,
  output logic                     done_o,
  output crk_pkg::crk_out_t        res_o
);
  import crk_pkg::*;

  crk_ustate_e                     state_q, state_d;
  logic [RankW-1:0]                x_q, x_d;
  logic [ModeW-1:0]                k_q, m_q;
  logic [HeightW-1:0]              hprev_q, best;
  logic [FieldModes-1:0][CountW-1:0] cnt_q, cnt_d;
  logic [TotalW-1:0]               tot_q;
  logic                            oor_q;
  logic [BinomW-1:0]               cand [MaxTotal+1];
  logic [MaxTotal:0]               fit;
  logic [RowIdxW-1:0]              lim_row;
  logic [BinomW-1:0]               limit;
  logic                            too_big;
  logic [ModeW-1:0]                pos_hi, pos_lo;

  assign lim_row = RowIdxW'(cfg_i.modes) + RowIdxW'(cfg_i.depth);
  assign limit   = Binom[lim_row][RowIdxW'(cfg_i.modes)];
  assign too_big = BinomW'(rank_i) >= limit;

  for (genvar h = 0; h <= MaxTotal; h++) begin : g_cand
    logic [RowIdxW-1:0] row;
    assign row     = RowIdxW'(k_q) + RowIdxW'(h) - RowIdxW'(1);
    assign cand[h] = Binom[row][RowIdxW'(k_q)];
    assign fit[h]  = (HeightW'(h) <= hprev_q) && (cand[h] <= BinomW'(x_q));
  end

  // Fits form a prefix in h; keep the last one
  always_comb begin
    best = '0;
    for (int h = 0; h <= MaxTotal; h++) begin
      if (fit[h]) begin
        best = HeightW'(h);
      end
    end
    x_d    = x_q - cand[best][RankW-1:0];
    pos_hi = m_q - k_q - ModeW'(1);
    pos_lo = m_q - ModeW'(1);
    cnt_d  = cnt_q;
    if (k_q < m_q) begin
      cnt_d[pos_hi[FieldIdxW-1:0]] = CountW'(hprev_q - best);
    end
    if (k_q == ModeW'(1)) begin
      cnt_d[pos_lo[FieldIdxW-1:0]] = CountW'(best);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      US_IDLE: begin
        if (start_i) begin
          state_d = too_big ? US_DONE : US_STEP;
        end
      end
      US_STEP: begin
        if (k_q == ModeW'(1)) begin
          state_d = US_DONE;
        end
      end
      US_DONE: begin
        if (ack_i) begin
          state_d = US_IDLE;
        end
      end
      default: state_d = US_IDLE;
    endcase
  end

  always_comb begin
    done_o             = (state_q == US_DONE);
    res_o.rank_out     = '0;
    res_o.counts_out   = cnt_q;
    res_o.total_out    = tot_q;
    res_o.out_of_range = oor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= US_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == US_IDLE && start_i) begin
      x_q     <= rank_i;
      k_q     <= cfg_i.modes;
      m_q     <= cfg_i.modes;
      hprev_q <= cfg_i.depth;
      cnt_q   <= '0;
      tot_q   <= '0;
      oor_q   <= too_big;
    end else if (state_q == US_STEP) begin
      x_q     <= x_d;
      k_q     <= k_q - ModeW'(1);
      hprev_q <= best;
      cnt_q   <= cnt_d;
      // first pass gives the layer
      if (k_q == m_q) begin
        tot_q <= TotalW'(best);
      end
    end
  end

endmodule

### sv/crk_checker.sv
// Port-level checker for the composition rank/unrank top, bound to it below.
// Depends on crk_pkg and composition_rank_unrank_top_defines.svh.
`include "composition_rank_unrank_top_defines.svh"

module crk_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input crk_pkg::crk_out_t out_data_o
);

  logic in_beat, out_held, flagged, one_kind;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign flagged  = out_valid_o && out_data_o.out_of_range;
  assign one_kind = (out_data_o.rank_out == '0) || (out_data_o.counts_out == '0);

  `CRK_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_data_o), "beat changed")

  `CRK_ASSERT_NEXT(a_one_in_flight, in_beat, in_stall_o, "second beat taken")

  `CRK_ASSERT_NOW(a_flag_clears_rank, flagged, out_data_o.rank_out == '0, "flagged rank")

  `CRK_ASSERT_NOW(a_one_result_kind, out_valid_o, one_kind, "both rank and counts")

endmodule

bind composition_rank_unrank_top crk_checker u_crk_checker (.*);

### test/tb_composition_rank_unrank_top.sv
// Self-checking testbench for composition_rank_unrank_top: rank and unrank beats
// are checked against an in-bench predictor under random sender gaps and receiver stalls.
// Depends on crk_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_composition_rank_unrank_top;
  import crk_pkg::*;

  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 80;
  localparam logic [CfgIdxW-1:0] RegSpare = REG_DEPTH_LIMIT + 1'b1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  crk_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  crk_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Local copy of the register file
  logic [ModeW-1:0]  cfg_modes = ResetModes;
  logic [DepthW-1:0] cfg_depth = ResetDepth;

  crk_out_t pending_conversions[$];
  int       bad_beats = 0;

  // Sender burst control and receiver stall pattern
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int phase_left = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  composition_rank_unrank_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned choose(int n, int k);
    longint unsigned r;
    r = 1;
    if (k < 0 || k > n) return 0;
    if (n >= TableRows) return 64'd1 << 40;
    for (int i = 0; i < k; i++) r = r * longint'(n - i) / longint'(i + 1);
    return r;
  endfunction

  function automatic int live_modes();
    int m;
    m = cfg_modes;
    if (m < 1) m = 1;
    if (m > Modes) m = Modes;
    if (m > FieldModes) m = FieldModes;
    return m;
  endfunction

  function automatic int live_depth();
    return (cfg_depth > MaxTotal) ? MaxTotal : int'(cfg_depth);
  endfunction

  function automatic crk_out_t expected_conversion(crk_in_t item);
    crk_out_t res;
    int m, d, tot, best, hprev;
    int hs[0:FieldModes];
    longint unsigned rk, x;
    res = '0;
    m = live_modes();
    d = live_depth();
    if (item.opcode == OP_RANK) begin
      tot = 0;
      rk = 0;
      // suffix sums run from the last active mode towards mode 0
      for (int k = 1; k <= m; k++) begin
        tot += item.counts_in[CountW*(m-k) +: CountW];
        rk += choose(k - 1 + tot, k);
      end
      res.total_out = TotalW'(tot);
      if (tot > d || rk > RankMax) res.out_of_range = 1'b1;
      else res.rank_out = RankW'(rk);
    end else begin
      x = item.rank_in;
      if (x >= choose(m + d, m)) begin
        res.out_of_range = 1'b1;
      end else begin
        hs[0] = 0;
        hprev = d;
        for (int k = m; k >= 1; k--) begin
          best = 0;
          for (int h = 0; h <= MaxTotal; h++) begin
            if (h <= hprev && choose(k - 1 + h, k) <= x) best = h;
          end
          x -= choose(k - 1 + best, k);
          hs[k] = best;
          hprev = best;
        end
        for (int k = 1; k <= m; k++) begin
          res.counts_out[CountW*(m-k) +: CountW] = CountW'(hs[k] - hs[k-1]);
        end
        res.total_out = TotalW'(hs[m]);
      end
    end
    return res;
  endfunction

  function automatic crk_in_t rank_of(logic [CountsW-1:0] counts);
    crk_in_t it;
    it.opcode = OP_RANK;
    it.counts_in = counts;
    it.rank_in = RankW'($urandom);
    return it;
  endfunction

  function automatic crk_in_t unrank_of(logic [RankW-1:0] idx);
    crk_in_t it;
    it.opcode = OP_UNRANK;
    it.counts_in = $urandom;
    it.rank_in = idx;
    return it;
  endfunction

  // Mostly well-formed vectors and in-range indexes, the rest noise
  function automatic crk_in_t random_item();
    crk_in_t it;
    int m, d, tot, sel, lane;
    longint unsigned span;
    it.opcode = $urandom_range(0, 1);
    it.counts_in = $urandom;
    it.rank_in = RankW'($urandom);
    m = live_modes();
    d = live_depth();
    sel = $urandom_range(0, 99);
    if (it.opcode == OP_RANK) begin
      if (sel < 80) begin
        for (int i = 0; i < FieldModes; i++) begin
          if (i < m || sel < 40) it.counts_in[CountW*i +: CountW] = '0;
        end
        tot = (sel >= 70) ? d + 1 : $urandom_range(0, d);
        repeat (tot) begin
          lane = $urandom_range(0, m - 1);
          if (it.counts_in[CountW*lane +: CountW] != '1) begin
            it.counts_in[CountW*lane +: CountW] += 1'b1;
          end
        end
      end
    end else begin
      span = choose(m + d, m);
      if (sel < 85) it.rank_in = RankW'(longint'($urandom) % span);
      else if (sel < 92 && span <= RankMax) it.rank_in = RankW'(span);
    end
    return it;
  endfunction

  task automatic send_item(input crk_in_t item);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) gap = $urandom_range(1, gap_max);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = item;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_conversions.push_back(expected_conversion(item));
  endtask

  // Drop valid and wait for every pending result, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ACTIVE_MODES) cfg_modes = val;
    else if (idx == REG_DEPTH_LIMIT) cfg_depth = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input int modes, input int depth);
    settle();
    write_reg(REG_ACTIVE_MODES, CfgDataW'(modes));
    write_reg(REG_DEPTH_LIMIT, CfgDataW'(depth));
  endtask

  task automatic test_reset_extremes();
    send_item(rank_of(32'h0000_0000));
    send_item(rank_of(32'h0000_0001));
    send_item(rank_of(32'h1000_0000));
    send_item(rank_of(32'h0000_000F));
    send_item(rank_of(32'hF000_0000));
    send_item(rank_of(32'h0000_0078));
    send_item(rank_of(32'h0000_0088));
    send_item(rank_of(32'h1111_1111));
    send_item(rank_of(32'hFFFF_FFFF));
    send_item(unrank_of(20'd0));
    send_item(unrank_of(20'd1));
    send_item(unrank_of(20'h55555));
    send_item(unrank_of(RankW'(choose(Modes + MaxTotal, Modes) - 1)));
    send_item(unrank_of(RankW'(choose(Modes + MaxTotal, Modes))));
    send_item(unrank_of(20'hAAAAA));
    send_item(unrank_of(20'hFFFFF));
  endtask

  task automatic test_register_clamps();
    // modes 0 behaves as one mode; upper modes are ignored on rank
    set_config(0, 0);
    send_item(rank_of(32'hFFFF_FFF0));
    send_item(rank_of(32'h0000_0001));
    send_item(unrank_of(20'd0));
    send_item(unrank_of(20'd1));
    set_config(15, 9);
    send_item(rank_of(32'h0000_0009));
    send_item(unrank_of(RankW'(choose(Modes + 9, Modes) - 1)));
    send_item(unrank_of(RankW'(choose(Modes + 9, Modes))));
    settle();
    write_reg(RegSpare, '1);
    set_config(1, 15);
    send_item(rank_of(32'h0000_000F));
    send_item(unrank_of(20'd15));
    send_item(unrank_of(20'd16));
  endtask

  task automatic test_back_pressure();
    set_config(8, 15);
    gap_max = 0;
    @(negedge clk);
    hold_req = 1'b1;
    repeat (40) send_item(random_item());
  endtask

  task automatic test_random_sweep();
    int modes_set[11] = '{8, 1, 1, 2, 3, 5, 8, 8, 6, 15, 0};
    int depth_set[11] = '{15, 15, 0, 7, 15, 4, 0, 1, 12, 15, 8};
    for (int p = 0; p < 11; p++) begin
      set_config(modes_set[p], depth_set[p]);
      gap_max = (p % 2 == 0) ? 0 : $urandom_range(1, 6);
      repeat (100) send_item(random_item());
    end
  endtask

  // Receiver: random stall phases, with a long counted hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      phase_left--;
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    crk_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_conversions.size() == 0) begin
        if (bad_beats < 10) $display("result beat with nothing pending: %h", out_data);
        bad_beats++;
      end else begin
        want = pending_conversions.pop_front();
        if (out_data.rank_out !== want.rank_out || out_data.counts_out !== want.counts_out ||
            out_data.total_out !== want.total_out ||
            out_data.out_of_range !== want.out_of_range) begin
          if (bad_beats < 10) begin
            $display("mismatch: expected rank %0d counts %h total %0d oor %b",
                     want.rank_out, want.counts_out, want.total_out, want.out_of_range);
            $display("          got      rank %0d counts %h total %0d oor %b",
                     out_data.rank_out, out_data.counts_out, out_data.total_out,
                     out_data.out_of_range);
          end
          bad_beats++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("composition_rank_unrank_top regression: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    gap_max = 3;
    test_reset_extremes();
    test_register_clamps();
    test_back_pressure();
    test_random_sweep();
    settle();
    if (bad_beats == 0 && pending_conversions.size() == 0) begin
      $display("composition_rank_unrank_top regression: pass");
    end else begin
      $display("composition_rank_unrank_top regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/crk_pkg.sv
sv/crk_rank.sv
sv/crk_unrank.sv
sv/composition_rank_unrank_top.sv
sv/crk_checker.sv
test/tb_composition_rank_unrank_top.sv
